// ----- rtl/core/rlns_pkg.sv -----
package rlns_pkg;

  // Default sizing
  localparam int DEF_MAX_READS   = 4096;
  localparam int DEF_LENGTH_BITS = 24;

  // Field widths fixed by the interface
  localparam int IN_LEN_W       = 24;
  localparam int KIND_W         = 3;
  localparam int PCT_W          = 7;
  localparam int STAT_W         = 32;
  localparam int MEAN_FRAC_BITS = 8;

  // Action codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_NSCORE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LONGEST = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MEDIAN  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MEAN    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd4;

  // N-score percent walk
  localparam logic [PCT_W-1:0] PCT_STEP  = 7'd5;
  localparam logic [PCT_W-1:0] PCT_FINAL = 7'd95;

  typedef struct packed {
    logic                action;
    logic [IN_LEN_W-1:0] read_length;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PCT_W-1:0]  percent;
    logic [STAT_W-1:0] stat_value;
    logic              overflow;
    logic              last;
  } result_t;

  // Classified command from the front to the back
  typedef struct packed {
    logic                finish;
    logic [IN_LEN_W-1:0] read_length;
  } cmd_t;

endpackage

// ----- rtl/core/rlns_front.sv -----
module rlns_front import rlns_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  output logic  cmd_valid,
  output cmd_t  cmd,
  input  logic  cmd_take
);

  cmd_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       wr;
  logic       rd;
  cmd_t       cmd_in;

  // Classify the incoming transaction
  always_comb begin
    cmd_in.finish      = (item.action == ACT_FINISH);
    cmd_in.read_length = item.read_length;
  end

  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slots[rp];
  assign wr        = push && !full;
  assign rd        = cmd_take && cmd_valid;

  // Store payload
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wp] <= cmd_in;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr) begin
        wp <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
      fill <= fill + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ----- rtl/core/rlns_outq.sv -----
module rlns_outq import rlns_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr_en,
  input  result_t wr_data,
  output logic    wr_full,
  input  logic    rd_en,
  output result_t rd_data,
  output logic    rd_empty
);

  result_t    slots [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] fill;
  logic       wr;
  logic       rd;

  assign wr_full  = (fill == 3'd4);
  assign rd_empty = (fill == 3'd0);
  assign rd_data  = slots[rp];
  assign wr       = wr_en && !wr_full;
  assign rd       = rd_en && !rd_empty;

  // Store result payload
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wp] <= wr_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 2'd0;
      rp   <= 2'd0;
      fill <= 3'd0;
    end else begin
      if (wr) begin
        wp <= wp + 2'd1;
      end
      if (rd) begin
        rp <= rp + 2'd1;
      end
      fill <= fill + {2'b0, wr} - {2'b0, rd};
    end
  end

endmodule

// ----- rtl/core/rlns_div.sv -----
module rlns_div #(
  parameter int DW = 32,
  parameter int NW = 13
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [NW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   dq;
  logic [NW-1:0]   rem;
  logic [NW-1:0]   dvs;
  logic [CNTW-1:0] cnt;
  logic            running;
  logic            finished;
  logic [NW:0]     trial;
  logic            ge;

  // One quotient bit per cycle, restoring form
  assign trial    = {rem, dq[DW-1]};
  assign ge       = (trial >= {1'b0, dvs});
  assign quotient = dq;
  assign done     = finished;

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (running) begin
      dq  <= {dq[DW-2:0], ge};
      rem <= ge ? NW'(trial - {1'b0, dvs}) : trial[NW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      finished <= 1'b0;
      cnt      <= '0;
    end else if (start) begin
      running  <= 1'b1;
      finished <= 1'b0;
      cnt      <= CNTW'(DW);
    end else if (running) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNTW'(1)) begin
        running  <= 1'b0;
        finished <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/rlns_back.sv -----
module rlns_back import rlns_pkg::*; #(
  parameter int MAX_READS   = DEF_MAX_READS,
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_take,
  output logic    res_push,
  output result_t res,
  input  logic    res_full
);

  localparam int LB = LENGTH_BITS;
  localparam int IW = $clog2(MAX_READS);
  localparam int CW = $clog2(MAX_READS + 1);
  localparam int XW = CW + 2;
  localparam int TW = LB + CW;
  localparam int HW = TW + 7;
  localparam int DW = TW + MEAN_FRAC_BITS;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_ERR      = 5'd1;
  localparam logic [4:0] S_B_RD     = 5'd2;
  localparam logic [4:0] S_B_WAIT   = 5'd3;
  localparam logic [4:0] S_SIFT_L   = 5'd4;
  localparam logic [4:0] S_SIFT_R   = 5'd5;
  localparam logic [4:0] S_SIFT_CMP = 5'd6;
  localparam logic [4:0] S_SIFT_END = 5'd7;
  localparam logic [4:0] S_X_RD0    = 5'd8;
  localparam logic [4:0] S_X_RDI    = 5'd9;
  localparam logic [4:0] S_X_WR     = 5'd10;
  localparam logic [4:0] S_W_START  = 5'd11;
  localparam logic [4:0] S_W_FIRST  = 5'd12;
  localparam logic [4:0] S_W_CHK    = 5'd13;
  localparam logic [4:0] S_W_ADD    = 5'd14;
  localparam logic [4:0] S_W_EMIT   = 5'd15;
  localparam logic [4:0] S_L_RD     = 5'd16;
  localparam logic [4:0] S_L_EMIT   = 5'd17;
  localparam logic [4:0] S_M_RD     = 5'd18;
  localparam logic [4:0] S_M_EMIT   = 5'd19;
  localparam logic [4:0] S_D_RUN    = 5'd20;

  // Length store
  logic [LB-1:0] mem [MAX_READS];
  logic          we;
  logic          re;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;
  logic [LB-1:0] wdata;
  logic [LB-1:0] rdata;

  // Control and datapath registers
  logic [4:0]       state;
  logic [CW-1:0]    count;
  logic [TW-1:0]    total;
  logic             dropped;
  logic [XW-1:0]    hn;
  logic [XW-1:0]    si;
  logic [XW-1:0]    bi;
  logic [XW-1:0]    ei;
  logic             building;
  logic [LB-1:0]    sv;
  logic [LB-1:0]    vl;
  logic [LB-1:0]    cur;
  logic [HW-1:0]    cum100;
  logic [HW-1:0]    thr;
  logic [CW-1:0]    idx;
  logic [PCT_W-1:0] pct;

  // Combinational helpers
  logic [31:0]   len_ext;
  logic [LB-1:0] len_in;
  logic          has_room;
  logic [XW-1:0] lc;
  logic [XW-1:0] rc;
  logic [XW-1:0] bim1;
  logic          use_r;
  logic [LB-1:0] cmin;
  logic [XW-1:0] cidx;
  logic [HW-1:0] r100;
  logic [HW-1:0] t5;
  logic [CW-1:0] idx1;
  logic          adv;
  logic [CW-1:0] half;

  // Mean divider
  logic          div_start;
  logic          div_done;
  logic [DW-1:0] quot;
  logic [63:0]   q64;
  logic [31:0]   mean_sat;

  assign len_ext  = 32'(cmd.read_length);
  assign len_in   = len_ext[LB-1:0];
  assign has_room = (count < CW'(MAX_READS));
  assign lc       = {si[XW-2:0], 1'b1};
  assign rc       = lc + 1'b1;
  assign bim1     = bi - 1'b1;
  assign use_r    = (rc < hn) && (rdata < vl);
  assign cmin     = use_r ? rdata : vl;
  assign cidx     = use_r ? rc : lc;
  assign r100     = (HW'(rdata) << 6) + (HW'(rdata) << 5) + (HW'(rdata) << 2);
  assign t5       = (HW'(total) << 2) + HW'(total);
  assign idx1     = idx + 1'b1;
  assign adv      = (cum100 < thr) && ((CW + 1)'(idx) + 1'b1 < (CW + 1)'(count));
  assign half     = count >> 1;
  assign q64      = 64'(quot);
  assign mean_sat = (q64[63:32] != 32'd0) ? 32'hFFFF_FFFF : q64[31:0];

  rlns_div #(
    .DW (DW),
    .NW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({total, {MEAN_FRAC_BITS{1'b0}}}),
    .divisor  (count),
    .done     (div_done),
    .quotient (quot)
  );

  // Store port: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // Drive store ports, handshakes and result payload
  always_comb begin
    we             = 1'b0;
    re             = 1'b0;
    waddr          = si[IW-1:0];
    wdata          = sv;
    raddr          = '0;
    cmd_take       = 1'b0;
    res_push       = 1'b0;
    div_start      = 1'b0;
    res.kind       = KIND_NSCORE;
    res.percent    = '0;
    res.stat_value = '0;
    res.overflow   = dropped;
    res.last       = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd_take = cmd_valid;
        if (cmd_valid && !cmd.finish && has_room) begin
          we    = 1'b1;
          waddr = count[IW-1:0];
          wdata = len_in;
        end
      end
      S_ERR: begin
        res.kind = KIND_ERROR;
        res.last = 1'b1;
        res_push = !res_full;
      end
      S_B_RD: begin
        re    = 1'b1;
        raddr = bim1[IW-1:0];
      end
      S_B_WAIT: begin
      end
      S_SIFT_L: begin
        if (lc >= hn) begin
          we = 1'b1;
        end else begin
          re    = 1'b1;
          raddr = lc[IW-1:0];
        end
      end
      S_SIFT_R: begin
        if (rc < hn) begin
          re    = 1'b1;
          raddr = rc[IW-1:0];
        end
      end
      S_SIFT_CMP: begin
        we    = 1'b1;
        wdata = (cmin < sv) ? cmin : sv;
      end
      S_SIFT_END: begin
      end
      S_X_RD0: begin
        re = 1'b1;
      end
      S_X_RDI: begin
        re    = 1'b1;
        raddr = ei[IW-1:0];
      end
      S_X_WR: begin
        we    = 1'b1;
        waddr = ei[IW-1:0];
        wdata = vl;
      end
      S_W_START: begin
        re = 1'b1;
      end
      S_W_FIRST: begin
      end
      S_W_CHK: begin
        if (adv) begin
          re    = 1'b1;
          raddr = idx1[IW-1:0];
        end
      end
      S_W_ADD: begin
      end
      S_W_EMIT: begin
        res.kind       = KIND_NSCORE;
        res.percent    = pct;
        res.stat_value = 32'(cur);
        res_push       = !res_full;
      end
      S_L_RD: begin
        re = 1'b1;
      end
      S_L_EMIT: begin
        res.kind       = KIND_LONGEST;
        res.stat_value = 32'(rdata);
        res_push       = !res_full;
      end
      S_M_RD: begin
        re    = 1'b1;
        raddr = half[IW-1:0];
      end
      S_M_EMIT: begin
        res.kind       = KIND_MEDIAN;
        res.stat_value = 32'(rdata);
        res_push       = !res_full;
        div_start      = !res_full;
      end
      S_D_RUN: begin
        res.kind       = KIND_MEAN;
        res.stat_value = mean_sat;
        res.last       = 1'b1;
        res_push       = div_done && !res_full;
      end
      default: begin
      end
    endcase
  end

  // Sequence loads, heap sort, walk and result emission
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      total    <= '0;
      dropped  <= 1'b0;
      building <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (!cmd.finish) begin
              if (has_room) begin
                count <= count + 1'b1;
                total <= total + TW'(len_in);
              end else begin
                dropped <= 1'b1;
              end
            end else if (count == '0 || total == '0) begin
              state <= S_ERR;
            end else if (count == CW'(1)) begin
              state <= S_W_START;
            end else begin
              bi       <= XW'(half);
              hn       <= XW'(count);
              building <= 1'b1;
              state    <= S_B_RD;
            end
          end
        end
        S_ERR: begin
          if (!res_full) begin
            count   <= '0;
            total   <= '0;
            dropped <= 1'b0;
            state   <= S_IDLE;
          end
        end
        S_B_RD: begin
          si    <= bim1;
          state <= S_B_WAIT;
        end
        S_B_WAIT: begin
          sv    <= rdata;
          state <= S_SIFT_L;
        end
        S_SIFT_L: begin
          state <= (lc >= hn) ? S_SIFT_END : S_SIFT_R;
        end
        S_SIFT_R: begin
          vl    <= rdata;
          state <= S_SIFT_CMP;
        end
        S_SIFT_CMP: begin
          if (cmin < sv) begin
            si    <= cidx;
            state <= S_SIFT_L;
          end else begin
            state <= S_SIFT_END;
          end
        end
        S_SIFT_END: begin
          if (building) begin
            if (bi == XW'(1)) begin
              building <= 1'b0;
              ei       <= hn - 1'b1;
              state    <= S_X_RD0;
            end else begin
              bi    <= bim1;
              state <= S_B_RD;
            end
          end else if (ei == XW'(1)) begin
            state <= S_W_START;
          end else begin
            ei    <= ei - 1'b1;
            state <= S_X_RD0;
          end
        end
        S_X_RD0: begin
          state <= S_X_RDI;
        end
        S_X_RDI: begin
          vl    <= rdata;
          state <= S_X_WR;
        end
        S_X_WR: begin
          sv    <= rdata;
          si    <= '0;
          hn    <= ei;
          state <= S_SIFT_L;
        end
        S_W_START: begin
          state <= S_W_FIRST;
        end
        S_W_FIRST: begin
          cur    <= rdata;
          cum100 <= r100;
          idx    <= '0;
          thr    <= t5;
          pct    <= PCT_STEP;
          state  <= S_W_CHK;
        end
        S_W_CHK: begin
          state <= adv ? S_W_ADD : S_W_EMIT;
        end
        S_W_ADD: begin
          cur    <= rdata;
          cum100 <= cum100 + r100;
          idx    <= idx1;
          state  <= S_W_CHK;
        end
        S_W_EMIT: begin
          if (!res_full) begin
            if (pct == PCT_FINAL) begin
              state <= S_L_RD;
            end else begin
              pct   <= pct + PCT_STEP;
              thr   <= thr + t5;
              state <= S_W_CHK;
            end
          end
        end
        S_L_RD: begin
          state <= S_L_EMIT;
        end
        S_L_EMIT: begin
          if (!res_full) begin
            state <= S_M_RD;
          end
        end
        S_M_RD: begin
          state <= S_M_EMIT;
        end
        S_M_EMIT: begin
          if (!res_full) begin
            state <= S_D_RUN;
          end
        end
        S_D_RUN: begin
          if (div_done && !res_full) begin
            count   <= '0;
            total   <= '0;
            dropped <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/read_length_nscore_stats_top.sv -----
// Read length N-score statistics. Load transactions (action 0) store one read length each
// and are taken at one per cycle while no finish is running; loads beyond MAX_READS are
// dropped and flagged in the overflow bit of that run's results. A finish transaction
// (action 1) heap-sorts the stored lengths in place through the one-write, one-read length
// store, walks the sorted list once for N5..N95, then reports longest, median and mean; the
// mean comes from a bit-serial divider over LENGTH_BITS + clog2(MAX_READS+1) + 8 dividend
// bits. A finish emits 22 results, or one error result when nothing was loaded or the
// total length is zero. A two-entry command queue accepts up to two transactions while a
// finish is running, and a four-entry result queue lets the engine run ahead of the
// consumer.
module read_length_nscore_stats_top import rlns_pkg::*; #(
  parameter int MAX_READS   = DEF_MAX_READS,
  parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_take;
  logic    res_push;
  result_t res;
  logic    res_full;

  rlns_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  rlns_back #(
    .MAX_READS   (MAX_READS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  rlns_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_push),
    .wr_data  (res),
    .wr_full  (res_full),
    .rd_en    (pop),
    .rd_data  (result),
    .rd_empty (empty)
  );

endmodule

// ----- bench/tb_read_length_nscore_stats_top.sv -----
`timescale 1ns / 1ps

module tb_read_length_nscore_stats_top;
  import rlns_pkg::*;

  localparam int MAX_READS   = DEF_MAX_READS;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int QUIET_TAIL  = 40;

  typedef struct {
    item_t it;
    bit    drain;
  } send_t;

  logic    clk;
  logic    rst;
  logic    push;
  logic    full;
  item_t   item;
  logic    empty;
  logic    pop;
  result_t result;

  read_length_nscore_stats_top i_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  send_t            pending_items[$];
  result_t          expected_stats[$];
  logic [31:0]      stored_lengths[$];
  logic [35:0]      run_total;
  logic             run_dropped;
  int               mismatches;
  int               cycles;
  bit               quiet;
  int               send_gap;
  int               pop_gap;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Build one expected result
  function automatic result_t make_stat(logic [KIND_W-1:0] k, logic [PCT_W-1:0] p,
                                        logic [STAT_W-1:0] v, logic l);
    result_t r;
    r.kind       = k;
    r.percent    = p;
    r.stat_value = v;
    r.overflow   = run_dropped;
    r.last       = l;
    return r;
  endfunction

  // Append one expected result
  task automatic queue_stat(result_t r);
    expected_stats.insert(expected_stats.size(), r);
  endtask

  // Apply one accepted transaction to the statistics predictor
  task automatic predict_stats(item_t it);
    logic [63:0] cum;
    logic [63:0] thr;
    logic [63:0] mean;
    int          idx;
    bit          any;
    int          n;
    if (it.action == ACT_LOAD) begin
      if (stored_lengths.size() < MAX_READS) begin
        stored_lengths.insert(stored_lengths.size(), 32'(it.read_length));
        run_total += 36'(it.read_length);
      end else begin
        run_dropped = 1'b1;
      end
    end else begin
      n = stored_lengths.size();
      if (n == 0 || run_total == 0) begin
        queue_stat(make_stat(KIND_ERROR, '0, '0, 1'b1));
      end else begin
        stored_lengths.rsort();
        for (int p = 5; p < 100; p += 5) begin
          cum = 0;
          thr = 64'(run_total) * p;
          idx = 0;
          any = 0;
          while (cum * 100 < thr && (!any || idx + 1 < n)) begin
            if (any) idx++;
            any = 1;
            cum += stored_lengths[idx];
          end
          queue_stat(make_stat(KIND_NSCORE, PCT_W'(p), stored_lengths[idx], 1'b0));
        end
        queue_stat(make_stat(KIND_LONGEST, '0, stored_lengths[0], 1'b0));
        queue_stat(make_stat(KIND_MEDIAN, '0, stored_lengths[n / 2], 1'b0));
        mean = (64'(run_total) * 256) / n;
        if (mean > 64'hFFFF_FFFF) mean = 64'hFFFF_FFFF;
        queue_stat(make_stat(KIND_MEAN, '0, mean[31:0], 1'b1));
      end
      stored_lengths.delete();
      run_total   = '0;
      run_dropped = 1'b0;
    end
  endtask

  // Check accepted results and feed accepted transactions to the predictor
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_stats.size() == 0) begin
          $error("unexpected result kind=%0d value=%0h", result.kind, result.stat_value);
          mismatches++;
        end else begin
          exp_r = expected_stats.pop_front();
          if (result.kind !== exp_r.kind) begin
            $error("kind: expected %0d, actual %0d", exp_r.kind, result.kind);
            mismatches++;
          end
          if (result.percent !== exp_r.percent) begin
            $error("percent: expected %0d, actual %0d", exp_r.percent, result.percent);
            mismatches++;
          end
          if (result.stat_value !== exp_r.stat_value) begin
            $error("stat_value: expected %0h, actual %0h", exp_r.stat_value, result.stat_value);
            mismatches++;
          end
          if (result.overflow !== exp_r.overflow) begin
            $error("overflow: expected %0b, actual %0b", exp_r.overflow, result.overflow);
            mismatches++;
          end
          if (result.last !== exp_r.last) begin
            $error("last: expected %0b, actual %0b", exp_r.last, result.last);
            mismatches++;
          end
        end
      end
      if (push && !full) predict_stats(item);
    end
  end

  // Drive transactions at the falling edge; hold the current one until accepted
  always @(negedge clk) begin
    logic  nxt_push;
    item_t nxt_item;
    send_t s;
    nxt_push = push;
    nxt_item = item;
    if (rst) begin
      nxt_push = 1'b0;
    end else if (!(push && full)) begin
      nxt_push = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_items.size() > 0) begin
        if (!pending_items[0].drain || (expected_stats.size() == 0 && !push)) begin
          s        = pending_items.pop_front();
          nxt_push = 1'b1;
          nxt_item = s.it;
          if (!quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 8);
        end
      end
    end
    push <= nxt_push;
    item <= nxt_item;
  end

  // Stall the result side in random bursts
  always @(negedge clk) begin
    logic nxt_pop;
    nxt_pop = 1'b1;
    if (rst) begin
      nxt_pop = 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap--;
      nxt_pop = 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      pop_gap = $urandom_range(0, 7);
      nxt_pop = 1'b0;
    end
    pop <= nxt_pop;
  end

  // Timeout
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Queue one transaction
  task automatic add_item(logic act, logic [IN_LEN_W-1:0] len, bit drain = 0);
    send_t s;
    s.it.action      = act;
    s.it.read_length = len;
    s.drain          = drain;
    pending_items.insert(pending_items.size(), s);
  endtask

  function automatic logic [IN_LEN_W-1:0] rand_length();
    case ($urandom_range(0, 3))
      0: return IN_LEN_W'($urandom_range(0, 20));
      1: return IN_LEN_W'($urandom_range(0, 4000));
      default: return IN_LEN_W'($urandom);
    endcase
  endfunction

  initial begin
    int n_items;
    int run_len;
    rst            = 1'b1;
    push           = 1'b0;
    pop            = 1'b0;
    item           = '0;
    run_total      = '0;
    run_dropped    = 1'b0;
    mismatches     = 0;
    cycles         = 0;
    quiet          = 0;
    send_gap       = 0;
    pop_gap        = 0;

    // Directed: empty finish, zero total, extremes, single read, ties
    add_item(ACT_FINISH, '1);
    add_item(ACT_LOAD, '0);
    add_item(ACT_LOAD, '0);
    add_item(ACT_FINISH, '0);
    add_item(ACT_LOAD, '1);
    add_item(ACT_FINISH, 24'h5A5A5A);
    add_item(ACT_LOAD, '1);
    add_item(ACT_LOAD, 24'd1);
    add_item(ACT_LOAD, 24'd0);
    add_item(ACT_LOAD, 24'hAAAAAA);
    add_item(ACT_LOAD, 24'h555555);
    add_item(ACT_FINISH, '0);
    add_item(ACT_LOAD, 24'd7);
    add_item(ACT_LOAD, 24'd7);
    add_item(ACT_LOAD, 24'd7);
    add_item(ACT_LOAD, 24'd7);
    add_item(ACT_FINISH, '0, 1);
    add_item(ACT_LOAD, 24'd100);
    add_item(ACT_LOAD, 24'd1);
    add_item(ACT_LOAD, 24'd1);
    add_item(ACT_FINISH, '0);

    // Random runs, mostly short
    n_items = 0;
    while (n_items < 250) begin
      run_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
      for (int i = 0; i < run_len; i++) begin
        add_item(ACT_LOAD, ($urandom_range(0, 15) == 0) ? '0 : rand_length(),
                 (i == 0) && ($urandom_range(0, 7) == 0));
      end
      add_item(ACT_FINISH, IN_LEN_W'($urandom));
      n_items += run_len + 1;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    wait (pending_items.size() < QUIET_TAIL);
    quiet = 1;
    wait (pending_items.size() == 0 && !push);
    wait (expected_stats.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/rlns_pkg.sv
rtl/core/rlns_front.sv
rtl/core/rlns_outq.sv
rtl/core/rlns_div.sv
rtl/core/rlns_back.sv
rtl/core/read_length_nscore_stats_top.sv
bench/tb_read_length_nscore_stats_top.sv
